>>> design/n163_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package n163_pkg;

	// Command codes of one input beat.
	typedef enum logic [1:0] {
		CMD_LOW_WRITE  = 2'd0,
		CMD_HIGH_WRITE = 2'd1,
		CMD_LOW_READ   = 2'd2,
		CMD_TICK       = 2'd3
	} cmd_t;

	localparam int unsigned SLOT_COUNT   = 15;
	localparam int unsigned PATTERN_SLOTS = 8;
	localparam int unsigned SLOT_W       = 4;
	localparam int unsigned ENTRY_W      = 9;
	localparam int unsigned COUNT_W      = 15;
	localparam int unsigned CHR_W        = 9;

	localparam logic [COUNT_W-1:0] TICK_STEP     = 15'd113;
	localparam logic [COUNT_W-1:0] CNT_MAX       = 15'h7FFF;
	localparam logic [COUNT_W-1:0] CNT_THRESHOLD = CNT_MAX - TICK_STEP;

	// Address region codes, address bits 15 to 11.
	localparam logic [4:0] REGION_COUNT_LO = 5'b01010;
	localparam logic [4:0] REGION_COUNT_HI = 5'b01011;
	localparam logic [4:0] REGION_TOP      = 5'b11111;
	localparam logic [15:0] ADDR_ZERO_READ = 16'h4800;

	localparam logic [SLOT_W-1:0] SLOT_FIRST_NT  = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_FIRST_CPU = 4'd12;
	localparam logic [SLOT_W-1:0] SLOT_FLAG_CPU  = 4'd13;

	localparam logic [7:0] PATTERN_RAM_MIN = 8'hE0;
	localparam logic [7:0] NT_ROM_MAX      = 8'hDF;
	localparam logic [7:0] CPU_BANK_MASK   = 8'h3F;

	localparam logic [CHR_W-1:0] CHR_MAX_BANKS = 9'd256;
	localparam logic [CHR_W-1:0] CHR_MIN_BANKS = 9'd8;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] address;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic              irq_request;
		logic              bank_changed;
		logic [SLOT_W-1:0] bank_slot;
		logic              bank_from_ram;
		logic [7:0]        bank_number;
	} result_t;

	// Handshake state between the input stage and the top level.
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctrl_t;

endpackage

`default_nettype wire

>>> design/n163_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one bus access or scanline tick per beat.
interface n163_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, output command, output address, output write_data,
		input ready);
	modport sink (input valid, input command, input address, input write_data,
		output ready);
endinterface

// Result channel: one result beat per accepted item.
interface n163_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_request;
	logic       bank_changed;
	logic [3:0] bank_slot;
	logic       bank_from_ram;
	logic [7:0] bank_number;

	modport source (output valid, output read_data, output irq_request,
		output bank_changed, output bank_slot, output bank_from_ram, output bank_number,
		input ready);
	modport sink (input valid, input read_data, input irq_request,
		input bank_changed, input bank_slot, input bank_from_ram, input bank_number,
		output ready);
endinterface

`default_nettype wire

>>> design/namco163_bank_and_irq_mapper.sv
// Namco 163 style bank and scanline IRQ mapper.
// The item channel takes one beat per CPU bus access or scanline tick:
// command 0 is a low-region write, 1 a high-region write, 2 a low-region
// read and 3 a scanline tick. Every accepted item yields exactly one beat
// on the result channel, in order: read data for reads, an IRQ request for
// ticks that saturate the counter, and the updated slot for bank writes.
// An item is held in the input register, where the counter, flags and
// slot table are updated and the result is formed, then moves to the
// result register, where its result becomes valid. One item is accepted
// every cycle while results are taken.
// When the receiver stalls, the result register holds its beat, the input
// register fills behind it and item ready drops until the result is taken.
// cfg_we with cfg_wdata reloads the pattern slots for that character ROM
// size; the user writes it only while the block is empty (not enforced).
// Reset clears the counter, enable and rom-only flags, loads the pattern
// slots for 256 banks and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module namco163_bank_and_irq_mapper (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire [n163_pkg::CHR_W-1:0] cfg_wdata,
	n163_item_if.sink                 item,
	n163_result_if.source             result
);

	n163_pkg::item_t       in_item;
	n163_pkg::item_t       item_s1;
	n163_pkg::stage_ctrl_t ctrl;
	n163_pkg::result_t     res;
	n163_pkg::result_t     result_s2;
	logic                  valid_s2;
	logic                  advance;
	logic                  in_ready;

	assign in_item.command    = n163_pkg::cmd_t'(item.command);
	assign in_item.address    = item.address;
	assign in_item.write_data = item.write_data;
	assign item.ready         = in_ready;

	// The input item moves on when the result register is free or drains.
	assign advance = ctrl.valid && (!valid_s2 || result.ready);

	n163_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_item  (in_item),
		.in_ready (in_ready),
		.advance  (advance),
		.item_s1  (item_s1),
		.ctrl     (ctrl)
	);

	n163_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item_s1   (item_s1),
		.ctrl      (ctrl),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign result.valid         = valid_s2;
	assign result.read_data     = result_s2.read_data;
	assign result.irq_request   = result_s2.irq_request;
	assign result.bank_changed  = result_s2.bank_changed;
	assign result.bank_slot     = result_s2.bank_slot;
	assign result.bank_from_ram = result_s2.bank_from_ram;
	assign result.bank_number   = result_s2.bank_number;

endmodule

`default_nettype wire

>>> design/n163_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module n163_in_stage (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  n163_pkg::item_t      in_item,
	output logic                 in_ready,
	input  wire                  advance,
	output n163_pkg::item_t      item_s1,
	output n163_pkg::stage_ctrl_t ctrl
);

	logic valid_s1;

	// The stage takes a new beat when empty or when its item moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload register needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign ctrl.valid   = valid_s1;
	assign ctrl.advance = advance;

endmodule

`default_nettype wire

>>> design/n163_core.sv
`timescale 1ns / 1ps
`default_nettype none

module n163_core (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [n163_pkg::CHR_W-1:0]  cfg_wdata,
	input  n163_pkg::item_t            item_s1,
	input  n163_pkg::stage_ctrl_t      ctrl,
	output n163_pkg::result_t          res
);

	logic [n163_pkg::COUNT_W-1:0] irq_count_q;
	logic                         irq_on_q;
	logic                         low_rom_only_q;
	logic                         high_rom_only_q;
	logic [n163_pkg::ENTRY_W-1:0] slot_table_q [n163_pkg::SLOT_COUNT];

	logic [4:0]                   region;
	logic [n163_pkg::SLOT_W-1:0]  slot;
	logic                         high_hit;
	logic                         rom_only;
	logic [n163_pkg::ENTRY_W-1:0] val;
	logic                         commit;
	logic                         tick_sat;
	logic [n163_pkg::CHR_W-1:0]   chr_banks;
	logic [7:0]                   pattern_base;
	logic [7:0]                   reset_base;

	assign region   = item_s1.address[15:11];
	assign slot     = item_s1.address[14:11];
	assign high_hit = item_s1.address[15] && (region != n163_pkg::REGION_TOP);
	assign rom_only = slot[2] ? high_rom_only_q : low_rom_only_q;
	assign commit   = ctrl.valid && ctrl.advance;
	assign tick_sat = irq_count_q >= n163_pkg::CNT_THRESHOLD;

	// Slot value for a high-region write.
	always_comb begin
		if (slot < n163_pkg::SLOT_FIRST_NT) begin
			if (item_s1.write_data < n163_pkg::PATTERN_RAM_MIN || rom_only) begin
				val = {1'b0, item_s1.write_data};
			end else begin
				val = {1'b1, 5'd0, slot[2:0]};
			end
		end else if (slot < n163_pkg::SLOT_FIRST_CPU) begin
			if (item_s1.write_data <= n163_pkg::NT_ROM_MAX) begin
				val = {1'b0, item_s1.write_data};
			end else begin
				val = {1'b1, 7'd0, item_s1.write_data[0]};
			end
		end else begin
			val = {1'b0, item_s1.write_data & n163_pkg::CPU_BANK_MASK};
		end
	end

	// Result fields of the item in the input register.
	always_comb begin
		res = '0;
		case (item_s1.command)
			n163_pkg::CMD_HIGH_WRITE: begin
				if (high_hit) begin
					res.bank_changed  = 1'b1;
					res.bank_slot     = slot;
					res.bank_from_ram = val[8];
					res.bank_number   = val[7:0];
				end
			end
			n163_pkg::CMD_LOW_READ: begin
				if (item_s1.address == n163_pkg::ADDR_ZERO_READ) begin
					res.read_data = 8'd0;
				end else if (region == n163_pkg::REGION_COUNT_LO) begin
					res.read_data = irq_count_q[7:0];
				end else if (region == n163_pkg::REGION_COUNT_HI) begin
					res.read_data = {1'b0, irq_count_q[14:8]};
				end else begin
					res.read_data = item_s1.address[15:8];
				end
			end
			n163_pkg::CMD_TICK: begin
				res.irq_request = irq_on_q && tick_sat;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Counter and rom-only flags advance once per committed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_count_q     <= '0;
			irq_on_q        <= 1'b0;
			low_rom_only_q  <= 1'b0;
			high_rom_only_q <= 1'b0;
		end else if (commit) begin
			case (item_s1.command)
				n163_pkg::CMD_LOW_WRITE: begin
					if (region == n163_pkg::REGION_COUNT_LO) begin
						irq_count_q[7:0] <= item_s1.write_data;
					end else if (region == n163_pkg::REGION_COUNT_HI) begin
						irq_count_q[14:8] <= item_s1.write_data[6:0];
						irq_on_q          <= item_s1.write_data[7];
					end
				end
				n163_pkg::CMD_HIGH_WRITE: begin
					if (high_hit && slot == n163_pkg::SLOT_FLAG_CPU) begin
						low_rom_only_q  <= item_s1.write_data[6];
						high_rom_only_q <= item_s1.write_data[7];
					end
				end
				n163_pkg::CMD_TICK: begin
					if (irq_on_q) begin
						irq_count_q <= tick_sat ? n163_pkg::CNT_MAX
							: irq_count_q + n163_pkg::TICK_STEP;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// First pattern bank for a given ROM size, clamped to 256 banks.
	assign chr_banks    = (cfg_wdata > n163_pkg::CHR_MAX_BANKS) ? n163_pkg::CHR_MAX_BANKS
		: cfg_wdata;
	assign pattern_base = (chr_banks >= n163_pkg::CHR_MIN_BANKS)
		? 8'(chr_banks - n163_pkg::CHR_MIN_BANKS) : 8'd0;
	assign reset_base   = 8'(n163_pkg::CHR_MAX_BANKS - n163_pkg::CHR_MIN_BANKS);

	// Bank slot table: loaded by reset and by a size write, updated by high writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < n163_pkg::SLOT_COUNT; i++) begin
				if (i < n163_pkg::PATTERN_SLOTS) begin
					slot_table_q[i] <= {1'b0, reset_base + 8'(i)};
				end else begin
					slot_table_q[i] <= '0;
				end
			end
		end else if (cfg_we) begin
			for (int i = 0; i < n163_pkg::PATTERN_SLOTS; i++) begin
				slot_table_q[i] <= (chr_banks >= n163_pkg::CHR_MIN_BANKS)
					? {1'b0, pattern_base + 8'(i)} : '0;
			end
		end else if (commit && item_s1.command == n163_pkg::CMD_HIGH_WRITE && high_hit) begin
			slot_table_q[slot] <= val;
		end
	end

	// A saturating tick leaves the counter at its top value.
	a_tick_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		commit && item_s1.command == n163_pkg::CMD_TICK && irq_on_q && tick_sat
		|=> irq_count_q == n163_pkg::CNT_MAX)
		else $error("counter did not saturate on an IRQ tick");

	// A slot update never names a slot beyond the table.
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.bank_changed |-> res.bank_slot < 4'(n163_pkg::SLOT_COUNT))
		else $error("bank update outside the slot table");

	// A disabled counter holds across a tick.
	a_tick_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		commit && item_s1.command == n163_pkg::CMD_TICK && !irq_on_q
		|=> $stable(irq_count_q))
		else $error("counter moved while disabled");

endmodule

`default_nettype wire
